// ===== design/edf_pkg.sv =====
`default_nettype none

package edf_pkg;

    // Widest slot index and time value over the legal parameter range.
    localparam int SLOT_MAX_BITS = 6;
    localparam int TIME_MAX_BITS = 32;

    typedef enum logic [2:0] {
        OP_CREATE     = 3'd0,
        OP_CREATE_DL  = 3'd1,
        OP_EXIT       = 3'd2,
        OP_SET_DL     = 3'd3,
        OP_YIELD      = 3'd4,
        OP_SLEEP      = 3'd5,
        OP_SCHEDULE   = 3'd6,
        OP_RESERVED   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DORMANT  = 2'd0,
        ST_READY    = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_SLEEPING = 2'd3
    } t_slot_state;

    localparam logic [1:0] CFG_DEFAULT_DEADLINE = 2'd0;
    localparam logic [1:0] CFG_MIN_STACK        = 2'd1;
    localparam logic [1:0] CFG_MAX_STACK        = 2'd2;

    // Search record that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic                     valid;
        logic [SLOT_MAX_BITS-1:0] cur;
        logic [SLOT_MAX_BITS-1:0] target;
        logic                     found;
        logic [SLOT_MAX_BITS-1:0] best_slot;
        logic [TIME_MAX_BITS-1:0] best_time;
        logic                     free_found;
        logic [SLOT_MAX_BITS-1:0] free_slot;
        logic                     any_live;
        t_slot_state              cur_state;
        logic [TIME_MAX_BITS-1:0] cur_dl;
        t_slot_state              target_state;
    } t_scan;

    // Write broadcast to all cells. Port 1 only marks a slot running and
    // takes priority over port 0.
    typedef struct packed {
        logic                     en0;
        logic [SLOT_MAX_BITS-1:0] slot0;
        logic                     set_state;
        t_slot_state              state;
        logic                     set_dl;
        logic                     set_rem;
        logic [TIME_MAX_BITS-1:0] dl;
        logic [TIME_MAX_BITS-1:0] rem;
        logic                     en1;
        logic [SLOT_MAX_BITS-1:0] slot1;
    } t_wr;

endpackage

`default_nettype wire

// ===== design/edf_if.sv =====
`default_nettype none

interface edf_task_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  target_slot;
    logic [30:0] deadline_value;
    logic [15:0] stack_bytes;
    modport source (output valid, operation, target_slot, deadline_value, stack_bytes,
                    input ready);
    modport sink   (input valid, operation, target_slot, deadline_value, stack_bytes,
                    output ready);
endinterface

interface edf_result_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [3:0] task_slot;
    logic       switch_request;
    modport source (output valid, status, task_slot, switch_request, input ready);
    modport sink   (input valid, status, task_slot, switch_request, output ready);
endinterface

interface edf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/edf_cell.sv =====
`default_nettype none

module edf_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire edf_pkg::t_scan i_scan,
    input  wire edf_pkg::t_wr   i_wr,
    output edf_pkg::t_scan      o_scan
);

    localparam logic [edf_pkg::SLOT_MAX_BITS-1:0] ID = edf_pkg::SLOT_MAX_BITS'(IDX);
    localparam logic [TIME_BITS-1:0] RST_TIME = (IDX == 0) ? {TIME_BITS{1'b1}} : '0;

    edf_pkg::t_slot_state r_state, n_state;
    logic [TIME_BITS-1:0] r_dl, n_dl;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    edf_pkg::t_scan       r_scan, n_scan;

    // Fold this slot into the passing search record.
    always_comb begin
        n_scan = i_scan;
        if (ID != '0) begin
            if ((r_state == edf_pkg::ST_READY || r_state == edf_pkg::ST_RUNNING) &&
                (!i_scan.found ||
                 edf_pkg::TIME_MAX_BITS'(r_rem) < i_scan.best_time)) begin
                n_scan.found     = 1'b1;
                n_scan.best_slot = ID;
                n_scan.best_time = edf_pkg::TIME_MAX_BITS'(r_rem);
            end
            if (r_state == edf_pkg::ST_DORMANT && !i_scan.free_found) begin
                n_scan.free_found = 1'b1;
                n_scan.free_slot  = ID;
            end
        end
        if (r_state != edf_pkg::ST_DORMANT) begin
            n_scan.any_live = 1'b1;
        end
        if (i_scan.cur == ID) begin
            n_scan.cur_state = r_state;
            n_scan.cur_dl    = edf_pkg::TIME_MAX_BITS'(r_dl);
        end
        if (i_scan.target == ID) begin
            n_scan.target_state = r_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_dl    = r_dl;
        n_rem   = r_rem;
        if (i_wr.en0 && i_wr.slot0 == ID) begin
            if (i_wr.set_state) begin
                n_state = i_wr.state;
            end
            if (i_wr.set_dl) begin
                n_dl = i_wr.dl[TIME_BITS-1:0];
            end
            if (i_wr.set_rem) begin
                n_rem = i_wr.rem[TIME_BITS-1:0];
            end
        end
        if (i_wr.en1 && i_wr.slot1 == ID) begin
            n_state = edf_pkg::ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= (IDX == 0) ? edf_pkg::ST_READY : edf_pkg::ST_DORMANT;
            r_dl         <= RST_TIME;
            r_rem        <= RST_TIME;
            r_scan.valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dl         <= n_dl;
            r_rem        <= n_rem;
            r_scan.valid <= n_scan.valid;
        end
        r_scan.cur          <= n_scan.cur;
        r_scan.target       <= n_scan.target;
        r_scan.found        <= n_scan.found;
        r_scan.best_slot    <= n_scan.best_slot;
        r_scan.best_time    <= n_scan.best_time;
        r_scan.free_found   <= n_scan.free_found;
        r_scan.free_slot    <= n_scan.free_slot;
        r_scan.any_live     <= n_scan.any_live;
        r_scan.cur_state    <= n_scan.cur_state;
        r_scan.cur_dl       <= n_scan.cur_dl;
        r_scan.target_state <= n_scan.target_state;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

// ===== design/edf_task_table_scheduler_top.sv =====
// Task table for an earliest-deadline-first scheduler.
// Channels: i_task carries one kernel operation per beat (operation, target_slot,
// deadline_value, stack_bytes); o_result returns exactly one beat per operation
// (status, task_slot, switch_request); i_cfg writes the default deadline and the
// stack limits and is always ready.
// Each task slot lives in one cell of a chain. An accepted operation launches a
// search record into the first cell; it moves one cell per cycle, gathering the
// earliest ready or running task, the lowest free slot and the state of the
// running and target slots. The last cell hands the record to the commit logic,
// which decides the result and broadcasts the table update to all cells at once.
// The result is registered once the search record has passed every cell and the
// commit logic; a new operation is accepted only after the previous one commits,
// as ready is high only in the idle state. The cell chain length sets the wait.
// A result waiting in the output register does not stop the next operation from
// being accepted; only its commit waits until the register is free.
// Synchronous reset puts slot 0 (the idle task) ready with the largest
// deadline, all other slots dormant, the running slot at 0, the live count at 0
// and the registers at 5, 512 and 32768.
`default_nettype none

module edf_task_table_scheduler_top #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 31
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    edf_task_if.sink      i_task,
    edf_result_if.source  o_result,
    edf_cfg_if.sink       i_cfg
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int LW = $clog2(TASK_SLOTS) + 1;
    localparam int MB = edf_pkg::SLOT_MAX_BITS;
    localparam int TB = edf_pkg::TIME_MAX_BITS;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_ctrl;

    t_ctrl r_state, n_state;

    // Configuration registers.
    logic [TIME_BITS-1:0] r_ddl;
    logic [15:0]          r_min_stack;
    logic [15:0]          r_max_stack;
    logic [TIME_BITS+30:0] cfg_wide;

    assign i_cfg.ready = 1'b1;
    assign cfg_wide    = {{TIME_BITS{1'b0}}, i_cfg.data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddl       <= TIME_BITS'(5);
            r_min_stack <= 16'd512;
            r_max_stack <= 16'd32768;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                edf_pkg::CFG_DEFAULT_DEADLINE: r_ddl       <= cfg_wide[TIME_BITS-1:0];
                edf_pkg::CFG_MIN_STACK:        r_min_stack <= i_cfg.data[15:0];
                edf_pkg::CFG_MAX_STACK:        r_max_stack <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // The operation held for the whole search.
    edf_pkg::t_op         r_op;
    logic [3:0]           r_target;
    logic [TIME_BITS-1:0] r_dl;
    logic [15:0]          r_stack;
    logic [SW-1:0]        r_cur;
    logic [LW-1:0]        r_live;
    logic                 r_go;
    edf_pkg::t_scan       r_res;
    logic [TIME_BITS+30:0] dl_wide;
    logic                 in_fire;

    assign i_task.ready = (r_state == S_IDLE);
    assign in_fire      = i_task.valid && i_task.ready;
    assign dl_wide      = {{TIME_BITS{1'b0}}, i_task.deadline_value};

    // Cell chain.
    edf_pkg::t_scan chain [TASK_SLOTS];
    edf_pkg::t_scan launch;
    edf_pkg::t_wr   wr;

    always_comb begin
        launch              = '0;
        launch.valid        = r_go;
        launch.cur          = MB'(r_cur);
        launch.target       = MB'(r_target);
        launch.cur_state    = edf_pkg::ST_DORMANT;
        launch.target_state = edf_pkg::ST_DORMANT;
    end

    for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
        edf_cell #(
            .IDX       (k),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  ((k == 0) ? launch : chain[(k == 0) ? 0 : k - 1]),
            .i_wr    (wr),
            .o_scan  (chain[k])
        );
    end

    // Commit logic: decide the result from the finished search record.
    logic                 commit;
    logic                 res_status;
    logic [MB-1:0]        res_slot;
    logic                 res_sw;
    logic                 n_cur_en;
    logic [MB-1:0]        n_cur;
    logic                 live_inc;
    logic                 live_dec;
    logic                 create_ok;
    logic [TIME_BITS-1:0] new_dl;
    logic [TB-1:0]        cmp_dl;
    logic                 cur_live;
    logic [MB-1:0]        chosen;

    assign commit = (r_state == S_DONE) && (!o_result.valid || o_result.ready);

    always_comb begin
        new_dl    = (r_op == edf_pkg::OP_CREATE) ? r_ddl : r_dl;
        create_ok = (r_stack >= r_min_stack) && (r_stack <= r_max_stack) &&
                    (r_live < LW'(TASK_SLOTS - 1)) && r_res.free_found;
        // A new task may land in the running slot after an exit; the
        // deadline compared is then the one just written.
        cmp_dl    = (r_res.free_slot == MB'(r_cur)) ? TB'(new_dl) : r_res.cur_dl;
        cur_live  = (r_res.cur_state != edf_pkg::ST_DORMANT);
        chosen    = r_res.found ? r_res.best_slot : '0;

        res_status = 1'b1;
        res_slot   = '0;
        res_sw     = 1'b0;
        n_cur_en   = 1'b0;
        n_cur      = chosen;
        live_inc   = 1'b0;
        live_dec   = 1'b0;
        wr         = '0;
        wr.state   = edf_pkg::ST_DORMANT;

        case (r_op)
            edf_pkg::OP_CREATE, edf_pkg::OP_CREATE_DL: begin
                if (create_ok && !(r_op == edf_pkg::OP_CREATE_DL && r_dl == '0)) begin
                    res_status   = 1'b0;
                    res_slot     = r_res.free_slot;
                    res_sw       = TB'(new_dl) < cmp_dl;
                    live_inc     = 1'b1;
                    wr.en0       = 1'b1;
                    wr.slot0     = r_res.free_slot;
                    wr.set_state = 1'b1;
                    wr.state     = edf_pkg::ST_READY;
                    wr.set_dl    = 1'b1;
                    wr.set_rem   = 1'b1;
                    wr.dl        = TB'(new_dl);
                    wr.rem       = TB'(new_dl);
                end
            end
            edf_pkg::OP_EXIT: begin
                if (r_cur != '0 && cur_live) begin
                    res_status   = 1'b0;
                    res_sw       = 1'b1;
                    live_dec     = (r_live != '0);
                    wr.en0       = 1'b1;
                    wr.slot0     = MB'(r_cur);
                    wr.set_state = 1'b1;
                    wr.state     = edf_pkg::ST_DORMANT;
                end
            end
            edf_pkg::OP_SET_DL: begin
                if (r_dl != '0 && r_target != '0 &&
                    7'(r_target) < 7'(TASK_SLOTS) &&
                    MB'(r_target) != MB'(r_cur) &&
                    r_res.target_state == edf_pkg::ST_READY) begin
                    res_status = 1'b0;
                    wr.en0     = 1'b1;
                    wr.slot0   = MB'(r_target);
                    wr.set_dl  = 1'b1;
                    wr.set_rem = 1'b1;
                    wr.dl      = TB'(r_dl);
                    wr.rem     = TB'(r_dl);
                end
            end
            edf_pkg::OP_YIELD: begin
                if (cur_live) begin
                    res_status = 1'b0;
                    res_sw     = 1'b1;
                    wr.en0     = 1'b1;
                    wr.slot0   = MB'(r_cur);
                    wr.set_rem = 1'b1;
                    wr.rem     = r_res.cur_dl;
                end
            end
            edf_pkg::OP_SLEEP: begin
                if (cur_live) begin
                    res_status   = 1'b0;
                    res_sw       = 1'b1;
                    wr.en0       = 1'b1;
                    wr.slot0     = MB'(r_cur);
                    wr.set_state = 1'b1;
                    wr.state     = edf_pkg::ST_SLEEPING;
                end
            end
            edf_pkg::OP_SCHEDULE: begin
                res_status = 1'b0;
                if (!r_res.any_live) begin
                    res_slot = MB'(r_cur);
                end else begin
                    res_slot     = chosen;
                    n_cur_en     = 1'b1;
                    wr.en0       = (r_res.cur_state == edf_pkg::ST_READY ||
                                    r_res.cur_state == edf_pkg::ST_RUNNING);
                    wr.slot0     = MB'(r_cur);
                    wr.set_state = 1'b1;
                    wr.state     = edf_pkg::ST_READY;
                    wr.en1       = 1'b1;
                    wr.slot1     = chosen;
                end
            end
            default: ;
        endcase

        if (!commit) begin
            wr.en0 = 1'b0;
            wr.en1 = 1'b0;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_SCAN;
            S_SCAN:  if (chain[TASK_SLOTS-1].valid) n_state = S_DONE;
            S_DONE:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic       r_out_valid;
    logic       r_out_status;
    logic [3:0] r_out_slot;
    logic       r_out_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_cur       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= in_fire;
            if (commit && n_cur_en) begin
                r_cur <= n_cur[SW-1:0];
            end
            if (commit && live_inc) begin
                r_live <= r_live + 1'b1;
            end else if (commit && live_dec) begin
                r_live <= r_live - 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire) begin
            r_op     <= edf_pkg::t_op'(i_task.operation);
            r_target <= i_task.target_slot;
            r_dl     <= dl_wide[TIME_BITS-1:0];
            r_stack  <= i_task.stack_bytes;
        end
        if (chain[TASK_SLOTS-1].valid) begin
            r_res <= chain[TASK_SLOTS-1];
        end
        if (commit) begin
            r_out_status <= res_status;
            r_out_slot   <= res_slot[3:0];
            r_out_sw     <= res_sw;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_status;
    assign o_result.task_slot      = r_out_slot;
    assign o_result.switch_request = r_out_sw;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_SCAN && r_go))
        else $error("accepted operation did not launch a search");

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= LW'(TASK_SLOTS - 1))
        else $error("live task count exceeds the usable slots");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a commit");

    a_search_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[TASK_SLOTS-1].valid |-> (r_state == S_SCAN))
        else $error("search record finished outside a scan");
`endif

endmodule

`default_nettype wire

// ===== test/edf_checker.sv =====
`timescale 1ns / 1ps

module edf_checker
    import edf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    edf_task_if        task_ch,
    edf_result_if      result_ch,
    edf_cfg_if         cfg_ch,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic       status;
        logic [3:0] task_slot;
        logic       switch_request;
    } t_result;

    t_slot_state tbl_state [16];
    logic [30:0] tbl_deadline [16];
    logic [30:0] tbl_remaining [16];
    logic [3:0]  cur_running;
    logic [4:0]  live_tasks;
    logic [30:0] dflt_deadline;
    logic [15:0] stack_min;
    logic [15:0] stack_max;
    t_result     expected_results [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_results.size();

    // Allocates the lowest dormant slot; returns 0 when the create is refused.
    function automatic logic [3:0] alloc_slot(input logic [15:0] stack,
                                              input logic [30:0] dl);
        if (stack < stack_min || stack > stack_max || live_tasks >= 5'd15)
            return 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (tbl_state[i] == ST_DORMANT) begin
                tbl_state[i]     = ST_READY;
                tbl_deadline[i]  = dl;
                tbl_remaining[i] = dl;
                live_tasks++;
                return 4'(i);
            end
        end
        return 4'd0;
    endfunction

    function automatic t_result predict_operation(input t_op op, input logic [3:0] tgt,
                                                  input logic [30:0] dl,
                                                  input logic [15:0] stack);
        t_result r;
        logic [3:0] s;
        logic [3:0] cur;
        logic any_live;
        logic found;
        logic [30:0] best_time;
        r   = '{status: 1'b1, task_slot: 4'd0, switch_request: 1'b0};
        cur = cur_running;
        case (op)
            OP_CREATE, OP_CREATE_DL: begin
                if (op == OP_CREATE || dl != 0) begin
                    s = alloc_slot(stack, op == OP_CREATE ? dflt_deadline : dl);
                    if (s != 0) begin
                        r.status = 1'b0;
                        r.task_slot = s;
                        r.switch_request = (tbl_deadline[s] < tbl_deadline[cur]);
                    end
                end
            end
            OP_EXIT: begin
                if (cur != 0 && tbl_state[cur] != ST_DORMANT) begin
                    tbl_state[cur] = ST_DORMANT;
                    if (live_tasks > 0) live_tasks--;
                    r.status = 1'b0;
                    r.switch_request = 1'b1;
                end
            end
            OP_SET_DL: begin
                if (dl != 0 && tgt != 0 && tgt != cur && tbl_state[tgt] == ST_READY) begin
                    tbl_deadline[tgt]  = dl;
                    tbl_remaining[tgt] = dl;
                    r.status = 1'b0;
                end
            end
            OP_YIELD, OP_SLEEP: begin
                if (tbl_state[cur] != ST_DORMANT) begin
                    if (op == OP_YIELD) tbl_remaining[cur] = tbl_deadline[cur];
                    else tbl_state[cur] = ST_SLEEPING;
                    r.status = 1'b0;
                    r.switch_request = 1'b1;
                end
            end
            OP_SCHEDULE: begin
                r.status = 1'b0;
                any_live = 1'b0;
                for (int i = 0; i < 16; i++)
                    if (tbl_state[i] != ST_DORMANT) any_live = 1'b1;
                if (!any_live) begin
                    r.task_slot = cur;
                end else begin
                    if (tbl_state[cur] == ST_READY || tbl_state[cur] == ST_RUNNING)
                        tbl_state[cur] = ST_READY;
                    // Earliest remaining time wins; a strict compare keeps ties low.
                    s = 4'd0;
                    found = 1'b0;
                    best_time = '0;
                    for (int i = 1; i < 16; i++) begin
                        if ((tbl_state[i] == ST_READY || tbl_state[i] == ST_RUNNING)
                            && (!found || tbl_remaining[i] < best_time)) begin
                            found = 1'b1;
                            s = 4'(i);
                            best_time = tbl_remaining[i];
                        end
                    end
                    tbl_state[s] = ST_RUNNING;
                    cur_running  = s;
                    r.task_slot  = s;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                tbl_state[i]     <= (i == 0) ? ST_READY : ST_DORMANT;
                tbl_deadline[i]  <= (i == 0) ? 31'h7fffffff : 31'd0;
                tbl_remaining[i] <= (i == 0) ? 31'h7fffffff : 31'd0;
            end
            cur_running   <= '0;
            live_tasks    <= '0;
            dflt_deadline <= 31'd5;
            stack_min     <= 16'd512;
            stack_max     <= 16'd32768;
            fails         <= 0;
            expected_results.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_DEFAULT_DEADLINE: dflt_deadline = cfg_ch.data;
                    CFG_MIN_STACK:        stack_min = cfg_ch.data[15:0];
                    CFG_MAX_STACK:        stack_max = cfg_ch.data[15:0];
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready) begin
                got = '{result_ch.status, result_ch.task_slot, result_ch.switch_request};
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat %p", got);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.task_slot !== want.task_slot) begin
                        $error("task_slot: expected %0d, got %0d",
                               want.task_slot, got.task_slot);
                        fails++;
                    end
                    if (got.switch_request !== want.switch_request) begin
                        $error("switch_request: expected %0d, got %0d",
                               want.switch_request, got.switch_request);
                        fails++;
                    end
                end
            end
            if (task_ch.valid && task_ch.ready)
                expected_results.push_back(predict_operation(t_op'(task_ch.operation),
                    task_ch.target_slot, task_ch.deadline_value, task_ch.stack_bytes));
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import edf_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off;    // receiver holds off for a long stretch when set
    bit   calm;        // no random idling on either side when set

    edf_task_if   task_ch ();
    edf_result_if result_ch ();
    edf_cfg_if    cfg_ch ();

    edf_task_table_scheduler_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    edf_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .task_ch      (task_ch),
        .result_ch    (result_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The receiver lowers ready at random with a 38 percent chance, never while calm,
    // and always during a hold-off.
    always @(negedge i_clk) begin
        if (hold_off)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= calm || ($urandom_range(99) >= 38);
    end

    // Sends one operation beat. Unless calm, idle cycles are inserted at random before it.
    task automatic send_operation(input t_op op, input logic [3:0] tgt,
                                  input logic [30:0] dl, input logic [15:0] stack);
        while (!calm && $urandom_range(99) < 38) begin
            task_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        task_ch.valid          <= 1'b1;
        task_ch.operation      <= op;
        task_ch.target_slot    <= tgt;
        task_ch.deadline_value <= dl;
        task_ch.stack_bytes    <= stack;
        do @(posedge i_clk); while (!task_ch.ready);
        @(negedge i_clk);
        task_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random operation. Most creates use a legal stack size so that the table
    // fills; small deadlines make ties and switch decisions common.
    task automatic send_random_operation();
        t_op         op;
        logic [30:0] dl;
        logic [15:0] stack;
        op = t_op'($urandom_range(7));
        if ($urandom_range(9) == 0) op = OP_RESERVED;
        else if (op == OP_RESERVED) op = OP_SCHEDULE;
        case ($urandom_range(3))
            0:       dl = 31'($urandom);
            1:       dl = 31'h7fffffff - 31'($urandom_range(3));
            default: dl = 31'($urandom_range(12));
        endcase
        if ($urandom_range(9) < 8) stack = 16'($urandom_range(512, 32768));
        else stack = 16'($urandom);
        send_operation(op, 4'($urandom_range(15)), dl, stack);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [30:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits for every expected result, then lets the chain drain.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
    endtask

    initial begin
        task_ch.valid          = 1'b0;
        task_ch.operation      = OP_CREATE;
        task_ch.target_slot    = '0;
        task_ch.deadline_value = '0;
        task_ch.stack_bytes    = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_DEFAULT_DEADLINE;
        cfg_ch.data            = '0;
        result_ch.ready        = 1'b0;
        hold_off               = 1'b0;
        calm                   = 1'b0;
        i_rst_n                = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. With an empty table the idle task cannot exit, and
        // schedule keeps slot 0.
        send_operation(OP_EXIT, 4'd0, 31'd0, 16'd0);
        send_operation(OP_SCHEDULE, 4'd0, 31'd0, 16'd0);
        send_operation(OP_CREATE, 4'd0, 31'd0, 16'd511);           // stack too small
        send_operation(OP_CREATE, 4'd0, 31'd0, 16'd32769);         // stack too large
        send_operation(OP_CREATE, 4'd0, 31'd0, 16'd512);
        send_operation(OP_CREATE_DL, 4'd0, 31'd0, 16'd1000);       // zero deadline
        send_operation(OP_CREATE_DL, 4'd0, 31'h7fffffff, 16'd32768);
        send_operation(OP_CREATE_DL, 4'd0, 31'd5, 16'd600);        // ties with slot 1
        send_operation(OP_SET_DL, 4'd0, 31'd3, 16'd0);             // idle slot
        send_operation(OP_SET_DL, 4'd1, 31'd0, 16'd0);             // zero deadline
        send_operation(OP_SET_DL, 4'd9, 31'd3, 16'd0);             // dormant target
        send_operation(OP_SET_DL, 4'd2, 31'd1, 16'd0);
        send_operation(OP_SCHEDULE, 4'd0, 31'd0, 16'd0);
        send_operation(OP_SET_DL, 4'd2, 31'd4, 16'd0);             // running target
        send_operation(OP_YIELD, 4'd0, 31'd0, 16'd0);
        send_operation(OP_SLEEP, 4'd0, 31'd0, 16'd0);
        send_operation(OP_SCHEDULE, 4'd0, 31'd0, 16'd0);
        send_operation(OP_EXIT, 4'd0, 31'd0, 16'd0);
        send_operation(OP_YIELD, 4'd0, 31'd0, 16'd0);              // running slot dormant
        send_operation(OP_RESERVED, 4'hf, 31'h7fffffff, 16'hffff);
        wait_idle();

        // Configuration extremes, including a zero default deadline.
        write_register(CFG_DEFAULT_DEADLINE, 31'd0);
        write_register(CFG_MIN_STACK, 31'd0);
        write_register(CFG_MAX_STACK, 31'hffff);
        send_operation(OP_CREATE, 4'd0, 31'd0, 16'hffff);
        send_operation(OP_CREATE, 4'd0, 31'd0, 16'd0);
        send_operation(OP_SCHEDULE, 4'd0, 31'd0, 16'd0);
        wait_idle();

        // Random phases, each under a fresh setting. A full table shows up as
        // rejected creates, and every phase ends idle before the next write.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_register(CFG_DEFAULT_DEADLINE, 31'h7fffffff);
                1: write_register(CFG_DEFAULT_DEADLINE, 31'd1);
                3: begin
                    write_register(CFG_MIN_STACK, 31'hffff);
                    write_register(CFG_MAX_STACK, 31'd0);
                end
                4: begin
                    write_register(CFG_MIN_STACK, 31'd512);
                    write_register(CFG_MAX_STACK, 31'd32768);
                    write_register(CFG_DEFAULT_DEADLINE, 31'($urandom_range(1, 10)));
                end
                default: write_register(CFG_DEFAULT_DEADLINE, 31'($urandom));
            endcase
            calm = (phase == 5);
            if (phase == 2) begin
                // The receiver holds off while operations keep coming, so the
                // output register fills and the block stalls its input.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (140) send_random_operation();
            wait_idle();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
